FILE: src/accel_tilt_gyro_yaw_defines.svh
// Assertion macros used by the checker file of the tilt and yaw block.
`ifndef ACCEL_TILT_GYRO_YAW_DEFINES_SVH
`define ACCEL_TILT_GYRO_YAW_DEFINES_SVH

// A property that is checked on every rising clock edge outside reset.
`define ATGY_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// A signal that must hold its value while a word is stalled on a channel.
`define ATGY_ASSERT_HOLD(lbl, clk, rstn, vld, rdy, sig, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) \
        ((vld) && !(rdy)) |=> $stable(sig)) else $error(msg);

`endif

FILE: src/atgy_pkg.sv
// Package with the constants, types and helper functions of the tilt and yaw block.
`timescale 1ns / 1ps

package atgy_pkg;

    // Datapath widths of the CORDIC unit.
    localparam int DATA_W  = 28;
    localparam int ANGLE_LEN = 24;
    localparam int STEP_W  = 5;

    localparam logic signed [DATA_W-1:0] HALF_PI_Q24  = 28'sd26353589;
    localparam logic signed [16:0]       INV_GAIN_Q16 = 17'sd39797;
    localparam logic signed [27:0]       YAW_SCALE_Q40 = 28'sd78602642;
    localparam logic signed [15:0]       ROLL_LIMIT   = 16'sd25736;
    localparam logic signed [15:0]       PITCH_LIMIT  = 16'sd12868;

    // Working vector of the CORDIC unit with its zero-vector flag.
    typedef struct packed {
        logic signed [DATA_W-1:0] x;
        logic signed [DATA_W-1:0] y;
        logic signed [DATA_W-1:0] z;
        logic                     zero;
    } t_cvec;

    // Arctangent of 2^-i in Q.24 radians, rounded to nearest.
    function automatic logic signed [DATA_W-1:0] atan_q24(input logic [STEP_W-1:0] idx);
        logic signed [DATA_W-1:0] a;
        case (idx)
            5'd0:    a = 28'sd13176795;
            5'd1:    a = 28'sd7778716;
            5'd2:    a = 28'sd4110060;
            5'd3:    a = 28'sd2086331;
            5'd4:    a = 28'sd1047214;
            5'd5:    a = 28'sd524117;
            5'd6:    a = 28'sd262123;
            5'd7:    a = 28'sd131069;
            5'd8:    a = 28'sd65536;
            5'd9:    a = 28'sd32768;
            5'd10:   a = 28'sd16384;
            5'd11:   a = 28'sd8192;
            5'd12:   a = 28'sd4096;
            5'd13:   a = 28'sd2048;
            5'd14:   a = 28'sd1024;
            5'd15:   a = 28'sd512;
            5'd16:   a = 28'sd256;
            5'd17:   a = 28'sd128;
            5'd18:   a = 28'sd64;
            5'd19:   a = 28'sd32;
            5'd20:   a = 28'sd16;
            5'd21:   a = 28'sd8;
            5'd22:   a = 28'sd4;
            5'd23:   a = 28'sd2;
            default: a = '0;
        endcase
        return a;
    endfunction

    // Starting vector: a vector in the left half plane is turned by a quarter turn first.
    function automatic t_cvec cordic_load(input logic signed [DATA_W-1:0] x,
                                          input logic signed [DATA_W-1:0] y);
        t_cvec v;
        v.zero = (x == '0) && (y == '0);
        v.x    = x;
        v.y    = y;
        v.z    = '0;
        if (x < 0) begin
            if (y >= 0) begin
                v.x = y;
                v.y = -x;
                v.z = HALF_PI_Q24;
            end else begin
                v.x = -y;
                v.y = x;
                v.z = -HALF_PI_Q24;
            end
        end
        return v;
    endfunction

    // Converts a Q.24 angle to Q3.13 with rounding and clamps it to +/- lim.
    function automatic logic signed [15:0] angle_q13(input logic signed [DATA_W-1:0] z,
                                                     input logic signed [15:0] lim);
        logic signed [DATA_W:0] s;
        logic signed [17:0]     q;
        logic signed [15:0]     r;
        s = (DATA_W+1)'(z) + 29'sd1024;
        q = s[DATA_W:11];
        if (q > 18'(lim)) begin
            r = lim;
        end else if (q < -18'(lim)) begin
            r = -lim;
        end else begin
            r = q[15:0];
        end
        return r;
    endfunction

endpackage

FILE: src/atgy_ifs.sv
// Channel interfaces for the IMU sample words and the attitude result words.
`timescale 1ns / 1ps

interface atgy_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    logic signed [15:0] rate_z;
    logic        [15:0] step_us;

    modport source (output valid, accel_x, accel_y, accel_z, rate_z, step_us,
                    input ready);
    modport sink   (input valid, accel_x, accel_y, accel_z, rate_z, step_us,
                    output ready);
endinterface

interface atgy_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] roll;
    logic signed [14:0] pitch;
    logic signed [31:0] yaw;

    modport source (output valid, roll, pitch, yaw, input ready);
    modport sink   (input valid, roll, pitch, yaw, output ready);
endinterface

FILE: src/accel_tilt_gyro_yaw.sv
// Top level of the tilt and yaw block: shared CORDIC unit, sequencer and yaw integrator.
`timescale 1ns / 1ps

// Takes one IMU sample word and returns roll = atan2(ay, az) in radians Q3.13
// and pitch = atan2(-ax, |(ay, az)|) in radians Q2.13, together with a
// saturating Q16.16 yaw that integrates rate_z * pi/180 * step_us. One CORDIC
// vectoring unit does one rotation step per cycle and is used for both angles.
// The sample passes through the roll pass, the gain state, the pitch load
// state, the pitch pass and the output write before the result word is valid.
// The input is not ready during that time and is ready again from the same
// edge that makes the result valid, so a sample is only taken once the one
// before it is finished. A result waiting in the output register does not
// stop the next sample from being accepted and worked on; only when that next
// sample is finished while the earlier word is still unread does it wait in
// its last state, with the input not ready. Yaw is cleared by reset.
module accel_tilt_gyro_yaw #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    atgy_in_if.sink   i_in,
    atgy_out_if.source o_out
);
    import atgy_pkg::*;

    localparam int STEPS = (CORDIC_STEPS < ANGLE_LEN) ? CORDIC_STEPS : ANGLE_LEN;
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(STEPS - 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_ROLL  = 3'd1;
    localparam logic [2:0] S_GAIN  = 3'd2;
    localparam logic [2:0] S_PLOAD = 3'd3;
    localparam logic [2:0] S_PITCH = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    localparam logic signed [59:0] YAW_ROUND = 60'sh80_0000_0000;

    logic [2:0]               r_state;
    logic [STEP_W-1:0]        r_step;
    t_cvec                    r_vec;
    t_cvec                    n_vec;
    logic signed [15:0]       r_ax;
    logic signed [31:0]       r_rate_dt;
    logic signed [44:0]       r_mag_prod;
    logic signed [59:0]       r_yaw_prod;
    logic signed [15:0]       r_roll;
    logic signed [31:0]       r_yaw_acc;
    logic                     r_out_valid;
    logic signed [15:0]       r_out_roll;
    logic signed [14:0]       r_out_pitch;
    logic signed [31:0]       r_out_yaw;

    logic signed [DATA_W-1:0] dx;
    logic signed [DATA_W-1:0] dy;
    logic signed [DATA_W-1:0] ang;
    logic signed [44:0]       mag_round;
    logic signed [DATA_W-1:0] ax_neg;
    logic signed [15:0]       pitch_q13;
    logic signed [59:0]       yaw_sum;
    logic signed [19:0]       yaw_delta;
    logic signed [32:0]       yaw_wide;
    logic signed [31:0]       n_yaw;
    logic                     out_free;

    // One CORDIC vectoring step; a zero vector stays as it is.
    always_comb begin
        dx    = r_vec.y >>> r_step;
        dy    = r_vec.x >>> r_step;
        ang   = atan_q24(r_step);
        n_vec = r_vec;
        if (!r_vec.zero) begin
            if (!r_vec.y[DATA_W-1]) begin
                n_vec.x = r_vec.x + dx;
                n_vec.y = r_vec.y - dy;
                n_vec.z = r_vec.z + ang;
            end else begin
                n_vec.x = r_vec.x - dx;
                n_vec.y = r_vec.y + dy;
                n_vec.z = r_vec.z - ang;
            end
        end
    end

    // Gain-corrected magnitude and the negated x acceleration for the pitch pass.
    assign mag_round = r_mag_prod + 45'sd32768;
    assign ax_neg    = -{{(DATA_W-24){r_ax[15]}}, r_ax, 8'b0};
    assign pitch_q13 = angle_q13(r_vec.z, PITCH_LIMIT);

    // Yaw increment with rounding, then a saturating add.
    always_comb begin
        yaw_sum   = r_yaw_prod + YAW_ROUND;
        yaw_delta = yaw_sum[59:40];
        yaw_wide  = 33'(r_yaw_acc) + 33'(yaw_delta);
        if (yaw_wide[32] != yaw_wide[31]) begin
            n_yaw = yaw_wide[32] ? {1'b1, 31'b0} : {1'b0, {31{1'b1}}};
        end else begin
            n_yaw = yaw_wide[31:0];
        end
    end

    assign out_free = !r_out_valid || o_out.ready;

    // Sequencer and the shared CORDIC registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_step    <= '0;
            r_yaw_acc <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_in.valid) begin
                        r_vec     <= cordic_load({{(DATA_W-24){i_in.accel_z[15]}},
                                                  i_in.accel_z, 8'b0},
                                                 {{(DATA_W-24){i_in.accel_y[15]}},
                                                  i_in.accel_y, 8'b0});
                        r_ax      <= i_in.accel_x;
                        r_rate_dt <= 32'(i_in.rate_z) * 32'(signed'({1'b0, i_in.step_us}));
                        r_step    <= '0;
                        r_state   <= S_ROLL;
                    end
                end
                S_ROLL: begin
                    r_vec <= n_vec;
                    if (r_step == LAST_STEP) begin
                        r_state <= S_GAIN;
                    end else begin
                        r_step <= r_step + 1'b1;
                    end
                end
                S_GAIN: begin
                    r_roll     <= angle_q13(r_vec.z, ROLL_LIMIT);
                    r_mag_prod <= 45'(r_vec.x) * 45'(INV_GAIN_Q16);
                    r_yaw_prod <= 60'(r_rate_dt) * 60'(YAW_SCALE_Q40);
                    r_state    <= S_PLOAD;
                end
                S_PLOAD: begin
                    r_vec   <= cordic_load(mag_round[DATA_W+15:16], ax_neg);
                    r_step  <= '0;
                    r_state <= S_PITCH;
                end
                S_PITCH: begin
                    r_vec <= n_vec;
                    if (r_step == LAST_STEP) begin
                        r_state <= S_DONE;
                    end else begin
                        r_step <= r_step + 1'b1;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_yaw_acc <= n_yaw;
                        r_state   <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Output register: a finished word waits here until the sink takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_DONE && out_free) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && out_free) begin
            r_out_roll  <= r_roll;
            r_out_pitch <= pitch_q13[14:0];
            r_out_yaw   <= n_yaw;
        end
    end

    assign i_in.ready  = (r_state == S_IDLE);
    assign o_out.valid = r_out_valid;
    assign o_out.roll  = r_out_roll;
    assign o_out.pitch = r_out_pitch;
    assign o_out.yaw   = r_out_yaw;

endmodule

FILE: src/atgy_checker.sv
// Port-level checker for the tilt and yaw block and its bind to the top level.
`timescale 1ns / 1ps
`include "accel_tilt_gyro_yaw_defines.svh"

module atgy_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               i_in_ready,
    input logic               i_out_valid,
    input logic               i_out_ready,
    input logic signed [15:0] i_out_roll,
    input logic signed [14:0] i_out_pitch,
    input logic signed [31:0] i_out_yaw
);
    // A sample word keeps the block busy after it is taken.
    `ATGY_ASSERT(a_busy_after_accept, i_clk, i_rst_n, (i_in_valid && i_in_ready) |=> !i_in_ready, "input ready right after a sample was accepted")

    // Angles stay inside their clamp limits.
    `ATGY_ASSERT(a_roll_range, i_clk, i_rst_n, i_out_valid |-> (i_out_roll <= 16'sd25736 && i_out_roll >= -16'sd25736), "roll outside its limits")
    `ATGY_ASSERT(a_pitch_range, i_clk, i_rst_n, i_out_valid |-> (i_out_pitch <= 15'sd12868 && i_out_pitch >= -15'sd12868), "pitch outside its limits")

    // A stalled result word stays valid and its yaw unchanged.
    `ATGY_ASSERT(a_out_valid_hold, i_clk, i_rst_n, (i_out_valid && !i_out_ready) |=> i_out_valid, "result word dropped while stalled")
    `ATGY_ASSERT_HOLD(a_out_yaw_hold, i_clk, i_rst_n, i_out_valid, i_out_ready, i_out_yaw, "yaw changed while stalled")

endmodule

bind accel_tilt_gyro_yaw atgy_checker u_atgy_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_roll  (o_out.roll),
    .i_out_pitch (o_out.pitch),
    .i_out_yaw   (o_out.yaw)
);
